/* rtl/core/bbsp_pkg.sv */
`default_nettype none
package bbsp_pkg;
    localparam int unsigned MagicW = 32;
    localparam int unsigned ValW   = 64;
    localparam int unsigned NumNet = 4;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [MagicW-1:0] MagicMainRst    = 32'hD9B4BEF9;
    localparam logic [MagicW-1:0] MagicTestRst    = 32'hDAB5BFFA;
    localparam logic [MagicW-1:0] MagicTest3Rst   = 32'h0709110B;
    localparam logic [MagicW-1:0] MagicAltRst     = 32'hFEB4BEF9;

    localparam logic [CfgIdxW-1:0] REG_MAIN  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_TEST  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_TEST3 = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_ALT   = 2'd3;

    typedef enum logic [4:0] {
        P_HUNT, P_SIZE, P_VERSION, P_PREV, P_MERKLE, P_TIME, P_BITS, P_NONCE,
        P_TXCOUNT, P_TXVER, P_INCOUNT, P_INPREV, P_ININDEX, P_INSLEN,
        P_INSCRIPT, P_SEQ, P_OUTCOUNT, P_OUTVAL, P_OUTSLEN, P_OUTSCRIPT,
        P_LOCKTIME
    } pos_t;

    typedef struct packed {
        logic [4:0]      kind;
        logic [ValW-1:0] value;
        logic [1:0]      chunk;
        logic [1:0]      net;
        logic [31:0]     blk;
        logic            last;
    } rec_t;

    localparam int unsigned RecW = $bits(rec_t);

    function automatic logic [4:0] kind_of(input pos_t p);
        logic [4:0] k;
        begin
            case (p)
                P_INSCRIPT, P_OUTSCRIPT, P_HUNT: k = 5'd0;
                P_SEQ:      k = 5'd14;
                P_OUTCOUNT: k = 5'd15;
                P_OUTVAL:   k = 5'd16;
                P_OUTSLEN:  k = 5'd17;
                P_LOCKTIME: k = 5'd18;
                default:    k = 5'(p);
            endcase
            return k;
        end
    endfunction

    // fixed length in bytes, 0 for counts and scripts
    function automatic logic [5:0] len_of(input pos_t p);
        logic [5:0] l;
        begin
            case (p)
                P_SIZE, P_VERSION, P_TIME, P_BITS, P_NONCE, P_TXVER,
                P_ININDEX, P_SEQ, P_LOCKTIME: l = 6'd4;
                P_PREV, P_MERKLE, P_INPREV:   l = 6'd32;
                P_OUTVAL:                     l = 6'd8;
                default:                      l = 6'd0;
            endcase
            return l;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/core/bbsp_magic.sv */
`default_nettype none
module bbsp_magic (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [bbsp_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [bbsp_pkg::MagicW-1:0]  cfg_data,
    input  wire logic [bbsp_pkg::MagicW-1:0]  window,
    output logic                            hit,
    output logic [1:0]                      net
);
    logic [bbsp_pkg::MagicW-1:0] magic_reg [bbsp_pkg::NumNet];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg[0] <= bbsp_pkg::MagicMainRst;
            magic_reg[1] <= bbsp_pkg::MagicTestRst;
            magic_reg[2] <= bbsp_pkg::MagicTest3Rst;
            magic_reg[3] <= bbsp_pkg::MagicAltRst;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bbsp_pkg::REG_MAIN:  magic_reg[0] <= cfg_data;
                bbsp_pkg::REG_TEST:  magic_reg[1] <= cfg_data;
                bbsp_pkg::REG_TEST3: magic_reg[2] <= cfg_data;
                bbsp_pkg::REG_ALT:   magic_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // lowest network code wins
    always_comb begin
        hit = 1'b1;
        net = 2'd0;
        if (window == magic_reg[0])      net = 2'd0;
        else if (window == magic_reg[1]) net = 2'd1;
        else if (window == magic_reg[2]) net = 2'd2;
        else if (window == magic_reg[3]) net = 2'd3;
        else hit = 1'b0;
    end
endmodule
`default_nettype wire

/* rtl/core/bbsp_parse.sv */
`default_nettype none
module bbsp_parse (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      mhit,
    input  wire logic [1:0]                mnet,
    output logic [bbsp_pkg::MagicW-1:0]    window,
    output logic                           rec_valid,
    output bbsp_pkg::rec_t                 rec
);
    localparam int unsigned VW = bbsp_pkg::ValW;

    bbsp_pkg::pos_t pos_reg, pos_next, pos;
    logic [4:0]    cnt_reg, cnt_next;
    logic [VW-1:0] acc_reg, acc_next;
    logic [31:0]   win_reg, win_next;
    logic [2:0]    fill_reg, fill_next;
    logic [3:0]    vlen_reg, vlen_next;
    logic [VW-1:0] tx_reg, tx_next, in_reg, in_next, out_reg, out_next, scr_reg, scr_next;
    logic [1:0]    net_reg, net_next;
    logic [31:0]   blk_reg, blk_next;

    logic [VW-1:0] accb, v, oleft;
    logic [2:0]    sh;
    logic [5:0]    len;
    logic [4:0]    n, vn;
    logic          done, endb;

    // shifted window while hunting, taken straight from the held byte
    assign window = {data_byte, win_reg[31:8]};

    always_comb begin
        pos = pos_reg;
        if (pos_reg > bbsp_pkg::P_LOCKTIME) pos = bbsp_pkg::P_HUNT;
        pos_next = pos; cnt_next = cnt_reg; acc_next = acc_reg; win_next = win_reg;
        fill_next = fill_reg; vlen_next = vlen_reg; tx_next = tx_reg; in_next = in_reg;
        out_next = out_reg; scr_next = scr_reg; net_next = net_reg; blk_next = blk_reg;
        rec_valid = 1'b0; endb = 1'b0; done = 1'b0; v = acc_reg;
        len = bbsp_pkg::len_of(pos);
        n = cnt_reg;
        vn = 5'(cnt_reg - 5'd1);
        sh = (len != 6'd0) ? n[2:0] : vn[2:0];
        accb = acc_reg | ({56'd0, data_byte} << {sh, 3'b000});
        oleft = out_reg - 64'd1;
        rec.kind = bbsp_pkg::kind_of(pos);
        rec.chunk = 2'd0;
        rec.net = net_reg;
        rec.blk = blk_reg;
        rec.last = 1'b0;
        rec.value = v;

        if (pos == bbsp_pkg::P_HUNT) begin
            win_next = window;
            if (fill_reg < 3'd4) fill_next = fill_reg + 3'd1;
            if (fill_next == 3'd4 && mhit) begin
                net_next = mnet; fill_next = 3'd0; cnt_next = 5'd0; acc_next = '0;
                pos_next = bbsp_pkg::P_SIZE;
                rec_valid = 1'b1;
                rec.net = mnet; rec.value = {32'd0, window};
            end
        end else if (pos == bbsp_pkg::P_INSCRIPT || pos == bbsp_pkg::P_OUTSCRIPT) begin
            scr_next = scr_reg - 64'd1;
            if (scr_next == '0) begin
                if (pos == bbsp_pkg::P_INSCRIPT) pos_next = bbsp_pkg::P_SEQ;
                else begin
                    out_next = oleft;
                    pos_next = (oleft == '0) ? bbsp_pkg::P_LOCKTIME : bbsp_pkg::P_OUTVAL;
                end
            end
        end else if (len == 6'd32) begin
            acc_next = accb;
            cnt_next = n + 5'd1;
            if (n[2:0] == 3'd7) begin
                rec_valid = 1'b1; rec.value = accb; rec.chunk = n[4:3]; acc_next = '0;
                if (n == 5'd31) begin
                    cnt_next = 5'd0;
                    if (pos == bbsp_pkg::P_PREV) pos_next = bbsp_pkg::P_MERKLE;
                    else if (pos == bbsp_pkg::P_MERKLE) pos_next = bbsp_pkg::P_TIME;
                    else pos_next = bbsp_pkg::P_ININDEX;
                end
            end
        end else if (len != 6'd0) begin
            acc_next = accb;
            cnt_next = n + 5'd1;
            v = accb;
            done = ({1'b0, cnt_next} >= len);
        end else if (cnt_reg == 5'd0) begin
            if (data_byte < 8'hFD) begin
                v = {56'd0, data_byte}; done = 1'b1;
            end else begin
                vlen_next = (data_byte == 8'hFD) ? 4'd2 : (data_byte == 8'hFE) ? 4'd4 : 4'd8;
                cnt_next = 5'd1; acc_next = '0;
            end
        end else begin
            acc_next = accb;
            cnt_next = cnt_reg + 5'd1;
            v = accb;
            done = ({1'b0, vn[2:0]} + 4'd1 >= vlen_reg);
        end

        if (done) begin
            cnt_next = 5'd0; acc_next = '0; vlen_next = 4'd0;
            rec_valid = 1'b1;
            case (pos)
                bbsp_pkg::P_SIZE:    pos_next = bbsp_pkg::P_VERSION;
                bbsp_pkg::P_VERSION: pos_next = bbsp_pkg::P_PREV;
                bbsp_pkg::P_TIME:    pos_next = bbsp_pkg::P_BITS;
                bbsp_pkg::P_BITS:    pos_next = bbsp_pkg::P_NONCE;
                bbsp_pkg::P_NONCE:   pos_next = bbsp_pkg::P_TXCOUNT;
                bbsp_pkg::P_TXCOUNT: begin
                    tx_next = v;
                    if (v == '0) endb = 1'b1; else pos_next = bbsp_pkg::P_TXVER;
                end
                bbsp_pkg::P_TXVER:   pos_next = bbsp_pkg::P_INCOUNT;
                bbsp_pkg::P_INCOUNT: begin
                    in_next = v;
                    pos_next = (v == '0) ? bbsp_pkg::P_OUTCOUNT : bbsp_pkg::P_INPREV;
                end
                bbsp_pkg::P_ININDEX: pos_next = bbsp_pkg::P_INSLEN;
                bbsp_pkg::P_INSLEN: begin
                    scr_next = v;
                    pos_next = (v == '0) ? bbsp_pkg::P_SEQ : bbsp_pkg::P_INSCRIPT;
                end
                bbsp_pkg::P_SEQ: begin
                    in_next = in_reg - 64'd1;
                    pos_next = (in_next == '0) ? bbsp_pkg::P_OUTCOUNT : bbsp_pkg::P_INPREV;
                end
                bbsp_pkg::P_OUTCOUNT: begin
                    out_next = v;
                    pos_next = (v == '0) ? bbsp_pkg::P_LOCKTIME : bbsp_pkg::P_OUTVAL;
                end
                bbsp_pkg::P_OUTVAL: pos_next = bbsp_pkg::P_OUTSLEN;
                bbsp_pkg::P_OUTSLEN: begin
                    scr_next = v;
                    if (v == '0) begin
                        out_next = oleft;
                        pos_next = (oleft == '0) ? bbsp_pkg::P_LOCKTIME : bbsp_pkg::P_OUTVAL;
                    end else pos_next = bbsp_pkg::P_OUTSCRIPT;
                end
                bbsp_pkg::P_LOCKTIME: begin
                    tx_next = tx_reg - 64'd1;
                    if (tx_next == '0) endb = 1'b1; else pos_next = bbsp_pkg::P_TXVER;
                end
                default: pos_next = bbsp_pkg::P_HUNT;
            endcase
            rec.value = v;
            rec.last = endb;
            if (endb) begin
                blk_next = blk_reg + 32'd1;
                pos_next = bbsp_pkg::P_HUNT; fill_next = 3'd0; win_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= bbsp_pkg::P_HUNT; cnt_reg <= '0; acc_reg <= '0; win_reg <= '0;
            fill_reg <= '0; vlen_reg <= '0; tx_reg <= '0; in_reg <= '0; out_reg <= '0;
            scr_reg <= '0; net_reg <= '0; blk_reg <= '0;
        end else if (step) begin
            pos_reg <= pos_next; cnt_reg <= cnt_next; acc_reg <= acc_next;
            win_reg <= win_next; fill_reg <= fill_next; vlen_reg <= vlen_next;
            tx_reg <= tx_next; in_reg <= in_next; out_reg <= out_next;
            scr_reg <= scr_next; net_reg <= net_next; blk_reg <= blk_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/blockchain_block_stream_parser.sv */
`default_nettype none
// a byte is held in an input register; its record is registered in the output register once the byte is processed
// throughput: one byte per cycle; a waiting record does not stall input unless both
// the input register and output register are full
// reset: aresetn synchronous, active low; parser returns to magic hunt, magics to defaults
module blockchain_block_stream_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [111:0]     m_tdata,   // field_kind, field_value, chunk_index,
                                        // network_code, block_number, zero fill
    output logic             m_tlast,   // block_end
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    logic [7:0] in_byte_reg;
    logic       in_vld_reg;
    logic       step, rv, hit;
    logic [1:0] mnet;
    logic [31:0] window;
    bbsp_pkg::rec_t rec, out_reg;
    logic       out_vld_reg;

    // the held byte is processed once the output register can take a record
    assign step = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) in_vld_reg <= s_tvalid;
            if (step) out_vld_reg <= rv;
            else if (m_tready) out_vld_reg <= 1'b0;
        end
        if (s_tready && s_tvalid) in_byte_reg <= s_tdata;
        if (step && rv) out_reg <= rec;
    end

    bbsp_magic u_magic (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .window(window), .hit(hit), .net(mnet)
    );

    bbsp_parse u_parse (
        .aclk(aclk), .aresetn(aresetn), .step(step), .data_byte(in_byte_reg),
        .mhit(hit), .mnet(mnet), .window(window), .rec_valid(rv), .rec(rec)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {7'd0, out_reg.blk, out_reg.net, out_reg.chunk, out_reg.value,
                       out_reg.kind};
endmodule
`default_nettype wire

/* tb/sv/tb_blockchain_block_stream_parser.sv */
`timescale 1ns / 100ps
module tb_blockchain_block_stream_parser;

    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] value;
        logic [1:0]  chunk;
        logic [1:0]  net;
        logic [31:0] blk;
        logic        last;
    } field_rec_t;

    class field_scoreboard;
        field_rec_t pending[$];
        int unsigned mismatches;
        int unsigned reported;

        // predictor state
        bbsp_pkg::pos_t pos;
        logic [4:0]  nbytes;
        logic [63:0] acc;
        logic [31:0] window;
        logic [2:0]  fill;
        logic [3:0]  vlen;
        logic [63:0] tx_cnt, in_cnt, out_cnt, script_cnt;
        logic [1:0]  net;
        logic [31:0] blocks;
        logic [31:0] magic [bbsp_pkg::NumNet];

        function void reset_state();
            pos = bbsp_pkg::P_HUNT; nbytes = 0; acc = 0; window = 0; fill = 0; vlen = 0;
            tx_cnt = 0; in_cnt = 0; out_cnt = 0; script_cnt = 0; net = 0; blocks = 0;
            magic[bbsp_pkg::REG_MAIN] = bbsp_pkg::MagicMainRst;
            magic[bbsp_pkg::REG_TEST] = bbsp_pkg::MagicTestRst;
            magic[bbsp_pkg::REG_TEST3] = bbsp_pkg::MagicTest3Rst;
            magic[bbsp_pkg::REG_ALT] = bbsp_pkg::MagicAltRst;
        endfunction

        function void write_magic(logic [1:0] idx, logic [31:0] v);
            magic[idx] = v;
        endfunction

        function void push_rec(logic [4:0] k, logic [63:0] v, logic [1:0] c, logic e);
            field_rec_t r;
            r.kind = k; r.value = v; r.chunk = c; r.net = net; r.blk = blocks; r.last = e;
            pending.push_back(r);
        endfunction

        function logic [4:0] field_kind(bbsp_pkg::pos_t p);
            case (p)
                bbsp_pkg::P_SEQ:      return 5'd14;
                bbsp_pkg::P_OUTCOUNT: return 5'd15;
                bbsp_pkg::P_OUTVAL:   return 5'd16;
                bbsp_pkg::P_OUTSLEN:  return 5'd17;
                bbsp_pkg::P_LOCKTIME: return 5'd18;
                bbsp_pkg::P_HUNT, bbsp_pkg::P_INSCRIPT, bbsp_pkg::P_OUTSCRIPT: return 5'd0;
                default:              return 5'(p);
            endcase
        endfunction

        function int unsigned field_len(bbsp_pkg::pos_t p);
            case (p)
                bbsp_pkg::P_SIZE, bbsp_pkg::P_VERSION, bbsp_pkg::P_TIME, bbsp_pkg::P_BITS,
                bbsp_pkg::P_NONCE, bbsp_pkg::P_TXVER, bbsp_pkg::P_ININDEX, bbsp_pkg::P_SEQ,
                bbsp_pkg::P_LOCKTIME: return 4;
                bbsp_pkg::P_PREV, bbsp_pkg::P_MERKLE, bbsp_pkg::P_INPREV: return 32;
                bbsp_pkg::P_OUTVAL: return 8;
                default:            return 0;
            endcase
        endfunction

        function void next_output();
            out_cnt = out_cnt - 1;
            pos = (out_cnt == 0) ? bbsp_pkg::P_LOCKTIME : bbsp_pkg::P_OUTVAL;
        endfunction

        function void note_byte(logic [7:0] b);
            bbsp_pkg::pos_t p;
            int unsigned len;
            logic [4:0] n;
            logic [63:0] v;
            logic endb;
            int found;
            p = pos;
            if (p == bbsp_pkg::P_HUNT) begin
                window = {b, window[31:8]};
                if (fill < 4) fill = fill + 1;
                if (fill < 4) return;
                found = -1;
                for (int i = bbsp_pkg::NumNet - 1; i >= 0; i--)
                    if (window == magic[i]) found = i;
                if (found < 0) return;
                net = found[1:0]; fill = 0; nbytes = 0; acc = 0; pos = bbsp_pkg::P_SIZE;
                push_rec(5'd0, {32'd0, window}, 2'd0, 1'b0);
                return;
            end
            if (p == bbsp_pkg::P_INSCRIPT || p == bbsp_pkg::P_OUTSCRIPT) begin
                script_cnt = script_cnt - 1;
                if (script_cnt == 0) begin
                    if (p == bbsp_pkg::P_INSCRIPT) pos = bbsp_pkg::P_SEQ;
                    else next_output();
                end
                return;
            end
            len = field_len(p);
            if (len != 0) begin
                n = nbytes;
                acc = acc | ({56'd0, b} << (8 * n[2:0]));
                nbytes = n + 5'd1;
                if (len == 32) begin
                    if (n[2:0] != 3'd7) return;
                    v = acc; acc = 0;
                    push_rec(field_kind(p), v, n[4:3], 1'b0);
                    if (n == 5'd31) begin
                        nbytes = 0;
                        if (p == bbsp_pkg::P_PREV) pos = bbsp_pkg::P_MERKLE;
                        else if (p == bbsp_pkg::P_MERKLE) pos = bbsp_pkg::P_TIME;
                        else pos = bbsp_pkg::P_ININDEX;
                    end
                    return;
                end
                if (nbytes < len) return;
                v = acc;
            end else if (nbytes == 0) begin
                if (b < 8'hFD) v = {56'd0, b};
                else begin
                    vlen = (b == 8'hFD) ? 4'd2 : ((b == 8'hFE) ? 4'd4 : 4'd8);
                    nbytes = 1; acc = 0;
                    return;
                end
            end else begin
                n = {2'd0, 3'(nbytes - 5'd1)};
                acc = acc | ({56'd0, b} << (8 * n));
                nbytes = nbytes + 5'd1;
                if (n + 1 < vlen) return;
                v = acc;
            end
            nbytes = 0; acc = 0; vlen = 0; endb = 0;
            case (p)
                bbsp_pkg::P_SIZE:    pos = bbsp_pkg::P_VERSION;
                bbsp_pkg::P_VERSION: pos = bbsp_pkg::P_PREV;
                bbsp_pkg::P_TIME:    pos = bbsp_pkg::P_BITS;
                bbsp_pkg::P_BITS:    pos = bbsp_pkg::P_NONCE;
                bbsp_pkg::P_NONCE:   pos = bbsp_pkg::P_TXCOUNT;
                bbsp_pkg::P_TXCOUNT: begin
                    tx_cnt = v;
                    if (v == 0) endb = 1; else pos = bbsp_pkg::P_TXVER;
                end
                bbsp_pkg::P_TXVER:   pos = bbsp_pkg::P_INCOUNT;
                bbsp_pkg::P_INCOUNT: begin
                    in_cnt = v;
                    pos = (v == 0) ? bbsp_pkg::P_OUTCOUNT : bbsp_pkg::P_INPREV;
                end
                bbsp_pkg::P_ININDEX: pos = bbsp_pkg::P_INSLEN;
                bbsp_pkg::P_INSLEN: begin
                    script_cnt = v;
                    pos = (v == 0) ? bbsp_pkg::P_SEQ : bbsp_pkg::P_INSCRIPT;
                end
                bbsp_pkg::P_SEQ: begin
                    in_cnt = in_cnt - 1;
                    pos = (in_cnt == 0) ? bbsp_pkg::P_OUTCOUNT : bbsp_pkg::P_INPREV;
                end
                bbsp_pkg::P_OUTCOUNT: begin
                    out_cnt = v;
                    pos = (v == 0) ? bbsp_pkg::P_LOCKTIME : bbsp_pkg::P_OUTVAL;
                end
                bbsp_pkg::P_OUTVAL:  pos = bbsp_pkg::P_OUTSLEN;
                bbsp_pkg::P_OUTSLEN: begin
                    script_cnt = v;
                    if (v == 0) next_output(); else pos = bbsp_pkg::P_OUTSCRIPT;
                end
                bbsp_pkg::P_LOCKTIME: begin
                    tx_cnt = tx_cnt - 1;
                    if (tx_cnt == 0) endb = 1; else pos = bbsp_pkg::P_TXVER;
                end
                default: pos = bbsp_pkg::P_HUNT;
            endcase
            push_rec(field_kind(p), v, 2'd0, endb);
            if (endb) begin
                blocks = blocks + 1; pos = bbsp_pkg::P_HUNT; fill = 0; window = 0;
            end
        endfunction

        function void check_rec(field_rec_t got);
            field_rec_t exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("unexpected record kind=%0d value=%h", got.kind, got.value);
                end
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (reported < 10) begin
                    reported++;
                    $display("mismatch exp kind=%0d val=%h ch=%0d net=%0d blk=%0d end=%0b",
                             exp.kind, exp.value, exp.chunk, exp.net, exp.blk, exp.last);
                    $display("         got kind=%0d val=%h ch=%0d net=%0d blk=%0d end=%0b",
                             got.kind, got.value, got.chunk, got.net, got.blk, got.last);
                end
            end
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [111:0] m_tdata;
    logic         m_tlast;
    logic         cfg_we = 0;
    logic [1:0]   cfg_index = 0;
    logic [31:0]  cfg_data = 0;

    blockchain_block_stream_parser i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tlast, .cfg_we, .cfg_index, .cfg_data
    );

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    field_scoreboard fields = new();
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycles = 0;
    int unsigned bytes_sent = 0;
    localparam int unsigned CycleLimit = 400000;

    // output sampling and receiver stalls
    always @(posedge aclk) begin
        field_rec_t r;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            r.kind = m_tdata[4:0]; r.value = m_tdata[68:5]; r.chunk = m_tdata[70:69];
            r.net = m_tdata[72:71]; r.blk = m_tdata[104:73]; r.last = m_tlast;
            fields.check_rec(r);
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk)
        if (cycles > CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fields.note_byte(b);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_word(input logic [63:0] v, input int unsigned n);
        for (int i = 0; i < n; i++) send_byte(v[8*i +: 8]);
    endtask

    task automatic send_count(input logic [63:0] v, input int unsigned form);
        case (form)
            0: send_byte(v[7:0]);
            1: begin send_byte(8'hFD); send_word(v, 2); end
            2: begin send_byte(8'hFE); send_word(v, 4); end
            default: begin send_byte(8'hFF); send_word(v, 8); end
        endcase
    endtask

    task automatic send_small_count(input int unsigned v);
        int unsigned form;
        form = $urandom_range(9) < 7 ? 0 : $urandom_range(3);
        send_count(64'(v), form);
    endtask

    task automatic send_rand(input int unsigned n);
        for (int i = 0; i < n; i++) send_byte(8'($urandom));
    endtask

    task automatic send_block(input int unsigned idx, input int unsigned ntx);
        send_word({32'd0, fields.magic[idx]}, 4);
        send_rand(4 + 4 + 64 + 12);
        send_small_count(ntx);
        for (int t = 0; t < ntx; t++) begin
            int unsigned nin, nout, sl;
            nin = $urandom_range(2); nout = $urandom_range(2);
            send_rand(4);
            send_small_count(nin);
            for (int i = 0; i < nin; i++) begin
                send_rand(36);
                sl = $urandom_range(3);
                send_small_count(sl);
                send_rand(sl + 4);
            end
            send_small_count(nout);
            for (int o = 0; o < nout; o++) begin
                send_rand(8);
                sl = $urandom_range(3);
                send_small_count(sl);
                send_rand(sl);
            end
            send_rand(4);
        end
    endtask

    // called at a falling edge
    task automatic drain();
        s_tvalid <= 0;
        while (fields.pending.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] v);
        @(negedge aclk);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        @(negedge aclk);
        cfg_we <= 0;
        fields.write_magic(idx, v);
    endtask

    initial begin
        fields.reset_state();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: default magic, zero tx count, then long-count forms
        send_word({32'd0, fields.magic[bbsp_pkg::REG_MAIN]}, 4);
        send_rand(84);
        send_count(64'd0, 0);
        send_word({32'd0, fields.magic[bbsp_pkg::REG_ALT]}, 4);
        send_rand(84);
        send_count(64'h0100000000000001, 3);
        send_rand(4);
        send_count(64'd0, 1);
        send_count(64'd0, 2);
        send_rand(4);
        send_word(64'hFFFF_FFFF_FFFF_FFFF, 8);
        drain();
        // equal magics: lowest code wins; extremes of the registers
        write_cfg(bbsp_pkg::REG_MAIN, 32'h0000_0000);
        write_cfg(bbsp_pkg::REG_TEST, 32'h0000_0000);
        write_cfg(bbsp_pkg::REG_TEST3, 32'hFFFF_FFFF);
        write_cfg(bbsp_pkg::REG_ALT, 32'hFFFF_FFFF);
        send_rand(3);
        send_block(bbsp_pkg::REG_TEST, 1);
        send_block(bbsp_pkg::REG_TEST3, 1);
        drain();
        write_cfg(bbsp_pkg::REG_MAIN, bbsp_pkg::MagicMainRst);
        write_cfg(bbsp_pkg::REG_TEST, bbsp_pkg::MagicTestRst);
        write_cfg(bbsp_pkg::REG_TEST3, bbsp_pkg::MagicTest3Rst);
        write_cfg(bbsp_pkg::REG_ALT, bbsp_pkg::MagicAltRst);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 32 : 83) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 32 : 83) : 0;
            if (ph == 2) begin
                write_cfg(bbsp_pkg::REG_TEST, $urandom);
                write_cfg(bbsp_pkg::REG_TEST3, $urandom);
            end
            for (int k = 0; k < ((ph == 1 || ph == 2) ? 2 : 1); k++) begin
                if ($urandom_range(9) == 0) send_rand($urandom_range(12));
                send_block($urandom_range(bbsp_pkg::NumNet - 1), $urandom_range(1));
            end
            drain();
        end
        recv_stall_pct = 0;
        drain();
        if (fields.mismatches == 0 && fields.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
